// ----- rtl/rip_pkg.sv -----
// ----------------------------------------------------------------------------
// rip_pkg
// shared types and constants of the ring insert position finder
// ----------------------------------------------------------------------------
package rip_pkg;

   localparam int unsigned POS_W = 9;
   localparam int unsigned VAL_W = 32;
   localparam int unsigned REQ_W = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PLACE  = 2'd2;
   localparam logic [REQ_W-1:0] REQ_SORTED = 2'd3;

   // order modes
   localparam logic MODE_ASCEND  = 1'b0;
   localparam logic MODE_DESCEND = 1'b1;

   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   // controller to datapath
   typedef struct packed {
      logic capture;   // take a request beat, apply clear or push
      logic rd_start;  // read the top entry
      logic advance;   // keep the read entry as upper neighbor, read the next one down
      logic load_rsp;  // fill the result register
      logic use_scan;  // result position comes from the scan
   } rip_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_update; // latched request is clear or push
      logic empty;
      logic single;
      logic hit;       // current neighbor pair satisfies the query
      logic idx_zero;  // lower neighbor is the bottom entry
   } rip_status_type;

endpackage

// ----- rtl/rip_req_if.sv -----
// ----------------------------------------------------------------------------
// rip_req_if
// request channel: valid/ready with request code and value
// ----------------------------------------------------------------------------
interface rip_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [rip_pkg::REQ_W-1:0]            req_type;
   logic signed [rip_pkg::VAL_W-1:0]     value;

   modport source  (output valid, output req_type, output value, input ready);
   modport sink    (input valid, input req_type, input value, output ready);
   modport monitor (input valid, input req_type, input value, input ready);
endinterface

// ----- rtl/rip_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rip_rsp_if
// result channel: valid/ready with position, extremes and error flag
// ----------------------------------------------------------------------------
interface rip_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [rip_pkg::POS_W-1:0]            position;
   logic signed [rip_pkg::VAL_W-1:0]     max_value;
   logic signed [rip_pkg::VAL_W-1:0]     min_value;
   logic                                 error;

   modport source  (output valid, output position, output max_value, output min_value,
                    output error, input ready);
   modport sink    (input valid, input position, input max_value, input min_value,
                    input error, output ready);
   modport monitor (input valid, input position, input max_value, input min_value,
                    input error, input ready);
endinterface

// ----- rtl/rip_ram.sv -----
// ----------------------------------------------------------------------------
// rip_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rip_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 512
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rip_datapath.sv -----
// ----------------------------------------------------------------------------
// rip_datapath
// stack storage, running extremes, neighbor-pair scan and result register
// ----------------------------------------------------------------------------
module rip_datapath #(
   parameter int unsigned DEPTH = 512
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rip_pkg::rip_cmd_type               cmd,
   output rip_pkg::rip_status_type            status,
   input  logic [rip_pkg::REQ_W-1:0]          req_type,
   input  logic signed [rip_pkg::VAL_W-1:0]   req_value,
   input  logic                               csr_wr_en,
   input  logic                               csr_wr_data,
   output logic [rip_pkg::POS_W-1:0]          rsp_position,
   output logic signed [rip_pkg::VAL_W-1:0]   rsp_max_value,
   output logic signed [rip_pkg::VAL_W-1:0]   rsp_min_value,
   output logic                               rsp_error
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [rip_pkg::REQ_W-1:0]          type_ff, type_in;
   logic signed [rip_pkg::VAL_W-1:0]   target_ff, target_in;
   logic                               perr_ff, perr_in;
   logic [CW-1:0]                      fill_ff, fill_in;
   logic signed [rip_pkg::VAL_W-1:0]   max_ff, max_in;
   logic signed [rip_pkg::VAL_W-1:0]   min_ff, min_in;
   logic                               mode_ff, mode_in;
   logic signed [rip_pkg::VAL_W-1:0]   hi_ff, hi_in;
   logic [AW-1:0]                      idx_ff, idx_in;
   logic [rip_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic signed [rip_pkg::VAL_W-1:0]   rmax_ff, rmax_in;
   logic signed [rip_pkg::VAL_W-1:0]   rmin_ff, rmin_in;
   logic                               rerr_ff, rerr_in;

   logic                               full;
   logic                               push_ok;
   logic [AW-1:0]                      top_idx;
   logic                               rd_en;
   logic [AW-1:0]                      rd_addr;
   logic [rip_pkg::VAL_W-1:0]          rd_raw;
   logic signed [rip_pkg::VAL_W-1:0]   lo;
   logic [AW:0]                        idx_next;
   logic                               hit;

   assign full    = (fill_ff == CW'(DEPTH));
   assign push_ok = cmd.capture && (req_type == rip_pkg::REQ_PUSH) && !full;
   assign top_idx = AW'(fill_ff - CW'(1));
   assign rd_en   = cmd.rd_start || cmd.advance;
   assign rd_addr = cmd.rd_start ? top_idx : (idx_ff - AW'(1));

   rip_ram #(
      .WIDTH (rip_pkg::VAL_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push_ok),
      .wr_addr (AW'(fill_ff)),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign lo = rd_raw;

   // pair test: lo is entry idx, hi is entry idx+1
   always_comb begin
      hit = 1'b0;
      if (type_ff == rip_pkg::REQ_SORTED) begin
         hit = (hi_ff > lo);
      end else if (mode_ff == rip_pkg::MODE_ASCEND) begin
         if (target_ff > max_ff) begin
            hit = (hi_ff == max_ff);
         end else if (target_ff < min_ff) begin
            hit = (lo == min_ff);
         end else begin
            hit = (target_ff < lo) && (target_ff > hi_ff);
         end
      end else begin
         if (target_ff > max_ff) begin
            hit = (lo == max_ff);
         end else if (target_ff < min_ff) begin
            hit = (hi_ff == min_ff);
         end else begin
            hit = (target_ff < hi_ff) && (target_ff > lo);
         end
      end
   end

   assign idx_next = {1'b0, idx_ff} + (AW+1)'(1);

   always_comb begin
      type_in   = type_ff;
      target_in = target_ff;
      perr_in   = perr_ff;
      fill_in   = fill_ff;
      max_in    = max_ff;
      min_in    = min_ff;
      mode_in   = csr_wr_en ? csr_wr_data : mode_ff;
      hi_in     = hi_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      rmax_in   = rmax_ff;
      rmin_in   = rmin_ff;
      rerr_in   = rerr_ff;

      if (cmd.capture) begin
         type_in   = req_type;
         target_in = req_value;
         perr_in   = (req_type == rip_pkg::REQ_PUSH) && full;
         if (req_type == rip_pkg::REQ_CLEAR) begin
            fill_in = '0;
            max_in  = rip_pkg::VAL_MIN;
            min_in  = rip_pkg::VAL_MAX;
         end else if (push_ok) begin
            fill_in = fill_ff + CW'(1);
            if (req_value > max_ff) begin
               max_in = req_value;
            end
            if (req_value < min_ff) begin
               min_in = req_value;
            end
         end
      end

      if (cmd.rd_start) begin
         idx_in = top_idx;
      end else if (cmd.advance) begin
         idx_in = idx_ff - AW'(1);
         hi_in  = lo;
      end

      if (cmd.load_rsp) begin
         rmax_in = max_ff;
         rmin_in = min_ff;
         pos_in  = (cmd.use_scan && hit) ? rip_pkg::POS_W'(idx_next) : '0;
         if (type_ff == rip_pkg::REQ_PUSH) begin
            rerr_in = perr_ff;
         end else if (type_ff == rip_pkg::REQ_CLEAR) begin
            rerr_in = 1'b0;
         end else begin
            rerr_in = (fill_ff == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         max_ff  <= rip_pkg::VAL_MIN;
         min_ff  <= rip_pkg::VAL_MAX;
         mode_ff <= rip_pkg::MODE_ASCEND;
      end else begin
         fill_ff <= fill_in;
         max_ff  <= max_in;
         min_ff  <= min_in;
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      target_ff <= target_in;
      perr_ff   <= perr_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      rmax_ff   <= rmax_in;
      rmin_ff   <= rmin_in;
      rerr_ff   <= rerr_in;
   end

   assign status.is_update = (type_ff == rip_pkg::REQ_CLEAR) || (type_ff == rip_pkg::REQ_PUSH);
   assign status.empty     = (fill_ff == '0);
   assign status.single    = (fill_ff == CW'(1));
   assign status.hit       = hit;
   assign status.idx_zero  = (idx_ff == '0);

   assign rsp_position  = pos_ff;
   assign rsp_max_value = rmax_ff;
   assign rsp_min_value = rmin_ff;
   assign rsp_error     = rerr_ff;

endmodule

// ----- rtl/rip_controller.sv -----
// ----------------------------------------------------------------------------
// rip_controller
// sequencer for request intake, top-down scan and result handoff
// ----------------------------------------------------------------------------
module rip_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rip_pkg::rip_status_type   status,
   output rip_pkg::rip_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_FIRST  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.is_update || status.empty || status.single) begin
               if (out_free) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.rd_start = 1'b1;
               state_in     = ST_FIRST;
            end
         end
         ST_FIRST: begin
            cmd.advance = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.hit || status.idx_zero) begin
               if (out_free) begin
                  cmd.load_rsp = 1'b1;
                  cmd.use_scan = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_rsp) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- rtl/ring_insert_position_finder_core.sv -----
// ----------------------------------------------------------------------------
// ring_insert_position_finder_core
// stack of signed values with insert-place and sortedness queries
// ----------------------------------------------------------------------------
// One request beat at a time. Clear and push go from the request beat through
// the decide state to the result register. For a place or sortedness query the
// stack sits in a single-read-port ram and the scan walks it from the top down
// one entry per cycle, testing each neighbor pair, and stops at the first match
// or else at the bottom pair. Max and min are kept as running values on
// push, so no scan is needed for them. The result sits in an output register,
// and the next request beat is taken while it waits. A push onto a full stack
// or a query on an empty one returns error with position 0. The stack ram needs
// no clearing pass after reset: the fill count guards every read.
// ----------------------------------------------------------------------------
module ring_insert_position_finder_core #(
   parameter int unsigned DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   rip_req_if.sink     req_chan,
   rip_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   // command and status between sequencer and datapath
   rip_pkg::rip_cmd_type     cmd;
   rip_pkg::rip_status_type  status;

   // sequencer: intake, scan stepping, result valid
   rip_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage, extremes, pair test and result payload
   rip_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_type      (req_chan.req_type),
      .req_value     (req_chan.value),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_position  (rsp_chan.position),
      .rsp_max_value (rsp_chan.max_value),
      .rsp_min_value (rsp_chan.min_value),
      .rsp_error     (rsp_chan.error)
   );

endmodule

// ----- rtl/rip_checker.sv -----
// ----------------------------------------------------------------------------
// rip_checker
// port-level checks on the result channel, bound to the core
// ----------------------------------------------------------------------------
module rip_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [rip_pkg::POS_W-1:0]          rsp_position,
   input  logic signed [rip_pkg::VAL_W-1:0]   rsp_max_value,
   input  logic signed [rip_pkg::VAL_W-1:0]   rsp_min_value,
   input  logic                               rsp_error
);

   // result beat held until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // stalled payload holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_position) && $stable(rsp_max_value) &&
         $stable(rsp_min_value) && $stable(rsp_error))
      else $error("rsp payload changed while stalled");

   // an error beat never carries a position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_position == '0)
      else $error("error beat with nonzero position");

   // max below min only for an empty stack
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_max_value < rsp_min_value) |->
         (rsp_max_value == rip_pkg::VAL_MIN) && (rsp_min_value == rip_pkg::VAL_MAX))
      else $error("inconsistent max and min");

endmodule

bind ring_insert_position_finder_core rip_checker u_rip_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_position  (rsp_chan.position),
   .rsp_max_value (rsp_chan.max_value),
   .rsp_min_value (rsp_chan.min_value),
   .rsp_error     (rsp_chan.error)
);

// ----- test/ring_insert_position_finder_core_tb.sv -----
// ----------------------------------------------------------------------------
// ring_insert_position_finder_core_tb
// self-checking bench for the stack insert-place / sortedness finder
// ----------------------------------------------------------------------------
// A driver feeds request beats from a pending queue and a monitor checks every
// result beat against a bit-accurate prediction made when the request beat is
// accepted. Directed beats run first in both order modes. Random runs follow,
// mostly clear / push / query sequences over rotated sorted stacks. One phase
// fills the stack to the top and pushes past it. Both channels idle at random,
// with one quiet phase, one long result stall and drained phase boundaries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ring_insert_position_finder_core_tb;

   localparam int unsigned DEPTH       = 512;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned PRINT_LIMIT = 200;

   typedef struct {
      logic [rip_pkg::REQ_W-1:0]        kind;
      logic signed [rip_pkg::VAL_W-1:0] value;
   } stack_beat_type;

   typedef struct {
      logic [rip_pkg::POS_W-1:0]        position;
      logic signed [rip_pkg::VAL_W-1:0] hi;
      logic signed [rip_pkg::VAL_W-1:0] lo;
      logic                             error;
   } placement_type;

   logic clock       = 1'b0;
   logic reset       = 1'b1;
   logic csr_wr_en   = 1'b0;
   logic csr_wr_data = 1'b0;

   rip_req_if req_bus ();
   rip_rsp_if rsp_bus ();

   ring_insert_position_finder_core #(
      .DEPTH (DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // stimulus and scoreboard
   stack_beat_type pending_beats[$];
   placement_type  expected_results[$];
   int             run_values[$];

   // shadow of the block's state
   logic signed [rip_pkg::VAL_W-1:0] stack_mem [DEPTH];
   int unsigned                      stack_held;
   logic                             order_mode_q;

   // traffic shaping
   bit          steady_flow = 1'b0;  // no idling on either side
   bit          rx_hold     = 1'b0;  // long result stall
   int unsigned hold_mark   = '1;    // accepted beat count that starts the stall

   // bookkeeping
   int unsigned cycle_count     = 0;
   int unsigned mismatch_count  = 0;
   int unsigned accepted_beats  = 0;
   int unsigned checked_results = 0;
   int unsigned kind_seen [4]   = '{default: 0};
   int unsigned flagged_errors  = 0;
   int unsigned deepest_stack   = 0;
   int unsigned widest_position = 0;
   int unsigned mode_writes     = 0;

   initial forever #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   // scan from the top down for the insert slot of target t
   function automatic logic [rip_pkg::POS_W-1:0] find_slot(
      logic signed [rip_pkg::VAL_W-1:0] t,
      logic signed [rip_pkg::VAL_W-1:0] hi,
      logic signed [rip_pkg::VAL_W-1:0] lo);
      int unsigned i;
      i = stack_held - 1;
      if (order_mode_q == rip_pkg::MODE_ASCEND) begin
         if (t > hi)
            while (i > 0 && stack_mem[i] != hi) i--;
         else if (t < lo)
            while (i > 0 && stack_mem[i-1] != lo) i--;
         else
            while (i > 0 && !(t < stack_mem[i-1] && t > stack_mem[i])) i--;
      end else begin
         // mirrored rule: the stack grows upward
         if (t > hi)
            while (i > 0 && stack_mem[i-1] != hi) i--;
         else if (t < lo)
            while (i > 0 && stack_mem[i] != lo) i--;
         else
            while (i > 0 && !(t < stack_mem[i] && t > stack_mem[i-1])) i--;
      end
      return i[rip_pkg::POS_W-1:0];
   endfunction

   // highest index whose entry is above the one below it, ignores order mode
   function automatic logic [rip_pkg::POS_W-1:0] find_break();
      int unsigned i;
      i = stack_held - 1;
      while (i > 0) begin
         if (stack_mem[i] > stack_mem[i-1])
            return i[rip_pkg::POS_W-1:0];
         i--;
      end
      return '0;
   endfunction

   // apply one accepted request beat to the shadow state, return its result
   function automatic placement_type apply_request(stack_beat_type beat);
      placement_type r;
      r.position = '0;
      r.error    = 1'b0;
      r.hi       = rip_pkg::VAL_MIN;
      r.lo       = rip_pkg::VAL_MAX;
      case (beat.kind)
         rip_pkg::REQ_CLEAR: begin
            stack_held = 0;
         end
         rip_pkg::REQ_PUSH: begin
            if (stack_held >= DEPTH)
               r.error = 1'b1;
            else begin
               stack_mem[stack_held] = beat.value;
               stack_held++;
            end
         end
         default: ;
      endcase
      for (int unsigned k = 0; k < stack_held; k++) begin
         if (stack_mem[k] > r.hi) r.hi = stack_mem[k];
         if (stack_mem[k] < r.lo) r.lo = stack_mem[k];
      end
      if (beat.kind == rip_pkg::REQ_PLACE || beat.kind == rip_pkg::REQ_SORTED) begin
         if (stack_held == 0)
            r.error = 1'b1;
         else if (beat.kind == rip_pkg::REQ_PLACE)
            r.position = find_slot(beat.value, r.hi, r.lo);
         else
            r.position = find_break();
      end
      kind_seen[beat.kind]++;
      if (r.error) flagged_errors++;
      if (stack_held > deepest_stack) deepest_stack = stack_held;
      if (r.position > widest_position) widest_position = r.position;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : feed_requests
      logic           offer;
      stack_beat_type beat;
      if (reset) begin
         req_bus.valid    <= 1'b0;
         req_bus.req_type <= rip_pkg::REQ_CLEAR;
         req_bus.value    <= '0;
      end else begin
         // a beat moves on this edge: predict its result now
         if (req_bus.valid && req_bus.ready) begin
            beat = pending_beats.pop_front();
            expected_results.push_back(apply_request(beat));
            accepted_beats++;
         end
         // hold an offered beat until taken, otherwise maybe idle
         offer = req_bus.valid && !req_bus.ready;
         if (!offer)
            offer = pending_beats.size() > 0 && (steady_flow || $urandom_range(99) >= 14);
         req_bus.valid <= offer;
         if (offer) begin
            req_bus.req_type <= pending_beats[0].kind;
            req_bus.value    <= pending_beats[0].value;
         end
      end
   end

   // ------------------------------------------------------------------------
   // result monitor
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_results
      placement_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            checked_results++;
            if (expected_results.size() == 0) begin
               report_mismatch("result beat with nothing outstanding");
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.position !== want.position)
                  report_mismatch($sformatf("result %0d position %0d, want %0d",
                     checked_results, rsp_bus.position, want.position));
               if (rsp_bus.max_value !== want.hi)
                  report_mismatch($sformatf("result %0d max %0d, want %0d",
                     checked_results, rsp_bus.max_value, want.hi));
               if (rsp_bus.min_value !== want.lo)
                  report_mismatch($sformatf("result %0d min %0d, want %0d",
                     checked_results, rsp_bus.min_value, want.lo));
               if (rsp_bus.error !== want.error)
                  report_mismatch($sformatf("result %0d error %b, want %b",
                     checked_results, rsp_bus.error, want.error));
            end
         end
         rsp_bus.ready <= !rx_hold && (steady_flow || $urandom_range(99) >= 14);
      end
   end

   // long result stall while requests keep coming, so the block backs up
   initial begin
      wait (accepted_beats >= hold_mark);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("watchdog: %0d beats accepted, %0d results outstanding",
                  accepted_beats, expected_results.size());
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_beat(logic [rip_pkg::REQ_W-1:0] kind,
                             logic signed [rip_pkg::VAL_W-1:0] value);
      stack_beat_type b;
      b.kind  = kind;
      b.value = value;
      pending_beats.push_back(b);
   endtask

   // wait until no beat is pending, offered or awaiting its result, then settle
   task automatic drain();
      while (pending_beats.size() > 0 || req_bus.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // order mode is only written while the block is idle
   task automatic write_order_mode(logic mode);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      order_mode_q = mode;
      mode_writes++;
      @(negedge clock);
   endtask

   // rotated sorted contents in run_values; small spans give duplicates
   task automatic make_contents(int unsigned len, bit narrow, bit downward, int unsigned turn);
      run_values.delete();
      repeat (len) begin
         if (narrow)
            run_values.push_back(int'($urandom_range(40)) - 20);
         else
            run_values.push_back(int'($urandom));
      end
      run_values.sort();
      if (downward) run_values.reverse();
      if (len > 0)
         repeat (turn % len) run_values.push_back(run_values.pop_front());
   endtask

   // query target: gap midpoints, held values, their neighbors, extremes or random
   function automatic logic signed [rip_pkg::VAL_W-1:0] pick_target();
      int     n;
      int     j;
      longint a;
      longint b;
      n = run_values.size();
      if (n == 0) return $urandom;
      j = $urandom_range(n - 1);
      case ($urandom_range(6))
         0: return run_values[j];
         1: return run_values[j] + 1;
         2: return run_values[j] - 1;
         3: return rip_pkg::VAL_MAX;
         4: return rip_pkg::VAL_MIN;
         5: begin
            if (n < 2) return $urandom;
            if (j == n - 1) j--;
            a = run_values[j];
            b = run_values[j+1];
            return 32'((a + b) / 2);
         end
         default: return $urandom;
      endcase
   endfunction

   // extremes, every request code and the empty / single / no-gap cases
   task automatic queue_directed();
      queue_beat(rip_pkg::REQ_CLEAR,  0);
      queue_beat(rip_pkg::REQ_PLACE,  5);       // query of an empty stack
      queue_beat(rip_pkg::REQ_SORTED, 0);
      queue_beat(rip_pkg::REQ_PUSH,   100);
      queue_beat(rip_pkg::REQ_PLACE,  50);      // single entry
      queue_beat(rip_pkg::REQ_SORTED, 0);
      queue_beat(rip_pkg::REQ_CLEAR,  0);
      queue_beat(rip_pkg::REQ_PUSH,   30);
      queue_beat(rip_pkg::REQ_PUSH,   10);
      queue_beat(rip_pkg::REQ_PUSH,   70);
      queue_beat(rip_pkg::REQ_PUSH,   50);
      queue_beat(rip_pkg::REQ_PLACE,  60);      // between neighbors near the top
      queue_beat(rip_pkg::REQ_PLACE,  20);      // between neighbors near the bottom
      queue_beat(rip_pkg::REQ_PLACE,  100);     // past the maximum
      queue_beat(rip_pkg::REQ_PLACE,  5);       // below the minimum
      queue_beat(rip_pkg::REQ_PLACE,  70);      // equal to max, no gap found
      queue_beat(rip_pkg::REQ_SORTED, 0);
      queue_beat(rip_pkg::REQ_PUSH,   rip_pkg::VAL_MIN);
      queue_beat(rip_pkg::REQ_PUSH,   rip_pkg::VAL_MAX);
      queue_beat(rip_pkg::REQ_PLACE,  rip_pkg::VAL_MAX);
      queue_beat(rip_pkg::REQ_PLACE,  rip_pkg::VAL_MIN);
      queue_beat(rip_pkg::REQ_PLACE,  -1);
      queue_beat(rip_pkg::REQ_CLEAR,  -1);
      queue_beat(rip_pkg::REQ_PLACE,  0);       // empty again after clear
      queue_beat(rip_pkg::REQ_PUSH,   -1);
   endtask

   // mostly well-formed clear / push / query runs, some noise
   task automatic queue_random_run(int unsigned beats);
      int unsigned added;
      int unsigned len;
      added = 0;
      while (added < beats) begin
         if ($urandom_range(9) < 8) begin
            len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 14);
            make_contents(len, $urandom_range(3) == 0, $urandom_range(1),
                          $urandom_range(15));
            queue_beat(rip_pkg::REQ_CLEAR, $urandom);
            foreach (run_values[k]) queue_beat(rip_pkg::REQ_PUSH, run_values[k]);
            added += len + 1;
            repeat ($urandom_range(1, 5)) begin
               if ($urandom_range(4) == 0)
                  queue_beat(rip_pkg::REQ_SORTED, $urandom);
               else
                  queue_beat(rip_pkg::REQ_PLACE, pick_target());
               added++;
            end
         end else begin
            repeat ($urandom_range(1, 3)) begin
               queue_beat(2'($urandom_range(3)), $urandom);
               added++;
            end
         end
      end
   endtask

   task automatic queue_full_queries();
      queue_beat(rip_pkg::REQ_PLACE,  rip_pkg::VAL_MAX);
      queue_beat(rip_pkg::REQ_PLACE,  rip_pkg::VAL_MIN);
      queue_beat(rip_pkg::REQ_PLACE,  pick_target());
      queue_beat(rip_pkg::REQ_PLACE,  pick_target());
      queue_beat(rip_pkg::REQ_SORTED, 0);
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      int unsigned fill_start;
      stack_held   = 0;
      order_mode_q = rip_pkg::MODE_ASCEND;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed beats under both rules
      write_order_mode(rip_pkg::MODE_ASCEND);
      queue_directed();
      drain();
      write_order_mode(rip_pkg::MODE_DESCEND);
      queue_directed();
      drain();

      // short random runs, alternating rules
      for (int p = 0; p < 4; p++) begin
         write_order_mode((p % 2 == 0) ? rip_pkg::MODE_ASCEND : rip_pkg::MODE_DESCEND);
         queue_random_run(8);
         drain();
      end

      // fill to the top with rising values, then push past full;
      // the first part runs with no idling, the result stall comes later
      write_order_mode(rip_pkg::MODE_ASCEND);
      make_contents(DEPTH, 1'b0, 1'b0, 0);
      fill_start = accepted_beats;
      hold_mark  = fill_start + 300;
      steady_flow = 1'b1;
      queue_beat(rip_pkg::REQ_CLEAR, 0);
      foreach (run_values[k]) queue_beat(rip_pkg::REQ_PUSH, run_values[k]);
      repeat (3) queue_beat(rip_pkg::REQ_PUSH, $urandom);
      queue_full_queries();
      wait (accepted_beats >= fill_start + 200);
      steady_flow = 1'b0;
      drain();
      // same full stack under the other rule
      write_order_mode(rip_pkg::MODE_DESCEND);
      queue_full_queries();
      drain();

      // nothing outstanding: let any late beat show up
      repeat (DEPTH + 8) @(posedge clock);
      if (expected_results.size() > 0)
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

      $display("covered %0d beats: %0d clear, %0d push, %0d place, %0d sorted, %0d errors",
               accepted_beats, kind_seen[rip_pkg::REQ_CLEAR], kind_seen[rip_pkg::REQ_PUSH],
               kind_seen[rip_pkg::REQ_PLACE], kind_seen[rip_pkg::REQ_SORTED], flagged_errors);
      $display("deepest stack %0d, largest position %0d, %0d mode writes, %0d mismatches",
               deepest_stack, widest_position, mode_writes, mismatch_count);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
